FILE: hw/rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants for the stack machine evaluator
// Command codes, payload structs, controller states and ctrl/status structs.
// ----------------------------------------------------------------------------
package sme_pkg;

	typedef enum logic [3:0] {
		CMD_START = 4'd0,
		CMD_NUM   = 4'd1,
		CMD_POP   = 4'd2,
		CMD_INV   = 4'd3,
		CMD_DUP   = 4'd4,
		CMD_SWP   = 4'd5,
		CMD_ADD   = 4'd6,
		CMD_SUB   = 4'd7,
		CMD_MUL   = 4'd8,
		CMD_DIV   = 4'd9,
		CMD_MOD   = 4'd10,
		CMD_END   = 4'd11
	} cmd_t;

	localparam int VAL_W = 31;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 31'sd1000000000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = -31'sd1000000000;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] operand;
	} in_item_t;

	typedef struct packed {
		logic signed [30:0] value;
		logic               error;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD1,
		ST_RD2,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_DIVWAIT,
		ST_WB,
		ST_SWP2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic rd_top;    // issue read of entry depth-1
		logic rd_below;  // issue read of entry depth-2, latch top
		logic lat_below; // latch below operand
		logic mul_go;    // register product
		logic div_go;    // start divider
		logic push;      // write operand at depth, depth++
		logic dup;       // write top at depth, depth++
		logic pop;       // depth--
		logic inv;       // write -top at depth-1
		logic wr_res;    // write result at depth-2, depth--
		logic swp_a;     // write top at depth-2
		logic swp_b;     // write below at depth-1
		logic set_err;
		logic clr_run;   // depth=0, error=0
		logic emit;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic err;
		logic empty;
		logic lt2;
		logic full;
		logic opnd_bad;
		logic top_zero;
		logic res_bad;
		logic div_done;
		logic one;
	} stat_t;

endpackage

FILE: hw/rtl/stack_machine_evaluator_top.sv
// ----------------------------------------------------------------------------
// stack_machine_evaluator_top: integer stack machine calculator
//
// Channel  | Ports                      | Handshake
// ---------+----------------------------+-------------------------------
// in       | start, busy, in_item       | taken when start && !busy
// out      | done, out_item             | one-cycle strobe, no stall
//
// Item states: start/num/pop/end finish in IDLE; inv/dup pass RD1 and EXEC;
// swp adds RD2, SWP2; add/sub/mul RD2, WB; div/mod RD2, 30-step divider.
// Stack reads go through one registered memory read port, one per cycle.
// Reset clears depth, error and controller state; the stack memory is not cleared.
// The receiver cannot stall: the result shows on done for one cycle.
// ----------------------------------------------------------------------------
module stack_machine_evaluator_top #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sme_pkg::in_item_t  in_item,
	output logic               busy,
	output logic               done,
	output sme_pkg::out_item_t out_item
);
	import sme_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	sme_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .item(in_item),
		.stat(stat), .ctrl(ctrl), .busy(busy), .done(done)
	);

	sme_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_item),
		.ctrl(ctrl), .stat(stat), .result(out_item)
	);

endmodule

FILE: hw/rtl/sme_div.sv
// ----------------------------------------------------------------------------
// sme_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sme_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic signed [30:0]  dividend,
	input  logic signed [30:0]  divisor,
	output logic                done,
	output logic signed [30:0]  quot,
	output logic signed [30:0]  rem
);
	import sme_pkg::*;

	logic [29:0] n_q, d_q, r_q;
	logic [4:0]  cnt_q;
	logic        busy_q, qneg_q, rneg_q;
	logic [30:0] trial;
	logic [29:0] nd_abs, dd_abs;

	assign nd_abs = dividend[30] ? 30'(-dividend) : dividend[29:0];
	assign dd_abs = divisor[30]  ? 30'(-divisor)  : divisor[29:0];
	assign trial  = {r_q, n_q[29]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd29;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q    <= nd_abs;
			d_q    <= dd_abs;
			r_q    <= '0;
			qneg_q <= dividend[30] ^ divisor[30];
			rneg_q <= dividend[30];
		end else if (busy_q) begin
			if (!trial[30]) begin
				r_q <= trial[29:0];
				n_q <= {n_q[28:0], 1'b1};
			end else begin
				r_q <= {r_q[28:0], n_q[29]};
				n_q <= {n_q[28:0], 1'b0};
			end
		end
	end

	assign quot = qneg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
	assign rem  = rneg_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

FILE: hw/rtl/sme_datapath.sv
// ----------------------------------------------------------------------------
// sme_datapath: stack memory, depth/error registers and arithmetic
// ----------------------------------------------------------------------------
module sme_datapath #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sme_pkg::in_item_t item,
	input  sme_pkg::ctrl_t    ctrl,
	output sme_pkg::stat_t    stat,
	output sme_pkg::out_item_t result
);
	import sme_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic [VAL_W-1:0] mem [STACK_DEPTH];
	logic [VAL_W-1:0] rd_data_q;
	logic [DW-1:0]    depth_q;
	logic             err_q;
	logic signed [VAL_W-1:0] top_q, below_q, bottom_q;
	logic signed [61:0] prod_q;

	logic [AW-1:0]    rd_addr, wr_addr;
	logic             we;
	logic [VAL_W-1:0] wdata;
	logic signed [32:0] sum;
	logic signed [VAL_W-1:0] quot, rem, res;
	logic             div_done;

	sme_div u_div (
		.clk(clk), .arst_n(arst_n), .go(ctrl.div_go),
		.dividend(below_q), .divisor(top_q),
		.done(div_done), .quot(quot), .rem(rem)
	);

	// command latch, loaded on start, push and stack-read items
	logic [3:0] cur_cmd_q;
	always_ff @(posedge clk) begin
		if (ctrl.rd_top || ctrl.push || ctrl.clr_run) begin
			cur_cmd_q <= item.cmd;
		end
	end

	always_comb begin
		rd_addr = ctrl.rd_below ? AW'(depth_q - DW'(2)) : AW'(depth_q - DW'(1));
		we      = 1'b0;
		wr_addr = AW'(depth_q);
		wdata   = item.operand[VAL_W-1:0];
		unique case (1'b1)
			ctrl.push:   begin we = 1'b1; wr_addr = ctrl.clr_run ? '0 : AW'(depth_q); end
			ctrl.dup:    begin we = 1'b1; wdata = top_q; end
			ctrl.inv:    begin we = 1'b1; wr_addr = AW'(depth_q - DW'(1)); wdata = -top_q; end
			ctrl.wr_res: begin we = 1'b1; wr_addr = AW'(depth_q - DW'(2)); wdata = res; end
			ctrl.swp_a:  begin we = 1'b1; wr_addr = AW'(depth_q - DW'(2)); wdata = top_q; end
			ctrl.swp_b:  begin we = 1'b1; wr_addr = AW'(depth_q - DW'(1)); wdata = below_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wdata;
		rd_data_q <= mem[rd_addr];
		if (ctrl.rd_below) top_q <= rd_data_q;
		if (ctrl.lat_below) below_q <= rd_data_q;
		if (ctrl.mul_go) prod_q <= below_q * top_q;
		if (we && wr_addr == '0) bottom_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			err_q   <= 1'b0;
		end else begin
			if (ctrl.clr_run) begin
				depth_q <= '0;
				err_q   <= 1'b0;
			end
			if (ctrl.set_err) err_q <= 1'b1;
			if (ctrl.push || ctrl.dup) depth_q <= ctrl.clr_run ? DW'(1) : depth_q + DW'(1);
			if (ctrl.pop || ctrl.wr_res) depth_q <= depth_q - DW'(1);
		end
	end

	assign sum = (cur_cmd_q == CMD_SUB) ? 33'(below_q) - 33'(top_q) : 33'(below_q) + 33'(top_q);

	always_comb begin
		unique case (cur_cmd_q)
			CMD_MUL: res = prod_q[VAL_W-1:0];
			CMD_DIV: res = quot;
			CMD_MOD: res = rem;
			default: res = sum[VAL_W-1:0];
		endcase
	end

	always_comb begin
		stat.err      = err_q;
		stat.empty    = (depth_q == '0);
		stat.lt2      = (depth_q < DW'(2));
		stat.full     = (depth_q >= DW'(STACK_DEPTH));
		stat.one      = (depth_q == DW'(1));
		stat.opnd_bad = (item.operand > 32'sd1000000000) || (item.operand < -32'sd1000000000);
		stat.top_zero = (top_q == '0);
		stat.div_done = div_done;
		unique case (cur_cmd_q)
			CMD_MUL: stat.res_bad = (prod_q > 62'sd1000000000) || (prod_q < -62'sd1000000000);
			default: stat.res_bad = (sum > 33'sd1000000000) || (sum < -33'sd1000000000);
		endcase
	end

	always_comb begin
		result.error = err_q || depth_q != DW'(1);
		result.value = result.error ? '0 : bottom_q;
	end

endmodule

FILE: hw/rtl/sme_ctrl.sv
// ----------------------------------------------------------------------------
// sme_ctrl: command sequencer for the stack machine evaluator
// ----------------------------------------------------------------------------
module sme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sme_pkg::in_item_t item,
	input  sme_pkg::stat_t    stat,
	output sme_pkg::ctrl_t    ctrl,
	output logic              busy,
	output logic              done
);
	import sme_pkg::*;

	state_t state_q, state_d;
	logic [3:0] cmd_q, cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_START;
		end else begin
			state_q <= state_d;
			cmd_q   <= cmd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		ctrl    = '0;
		done    = 1'b0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d = item.cmd;
					priority if (item.cmd == CMD_START) begin
						ctrl.clr_run = 1'b1;
						if (stat.opnd_bad) ctrl.set_err = 1'b1;
						else ctrl.push = 1'b1;
					end else if (item.cmd == CMD_END) begin
						ctrl.emit = 1'b1;
						done = 1'b1;
					end else if (stat.err || item.cmd > CMD_END) begin
					end else if (item.cmd == CMD_NUM) begin
						if (stat.opnd_bad || stat.full) ctrl.set_err = 1'b1;
						else ctrl.push = 1'b1;
					end else if (item.cmd <= CMD_DUP) begin
						if (stat.empty) ctrl.set_err = 1'b1;
						else if (item.cmd == CMD_POP) ctrl.pop = 1'b1;
						else begin ctrl.rd_top = 1'b1; state_d = ST_RD1; end
					end else begin
						if (stat.lt2) ctrl.set_err = 1'b1;
						else begin ctrl.rd_top = 1'b1; state_d = ST_RD1; end
					end
				end
			end
			ST_RD1: begin
				ctrl.rd_below = 1'b1;
				state_d = (cmd_q <= CMD_DUP) ? ST_EXEC : ST_RD2;
			end
			ST_RD2: begin
				ctrl.lat_below = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (cmd_q)
					CMD_INV: ctrl.inv = 1'b1;
					CMD_DUP: begin
						if (stat.full) ctrl.set_err = 1'b1;
						else ctrl.dup = 1'b1;
					end
					CMD_SWP: begin ctrl.swp_a = 1'b1; state_d = ST_SWP2; end
					CMD_MUL: begin ctrl.mul_go = 1'b1; state_d = ST_WB; end
					CMD_DIV, CMD_MOD: begin
						if (stat.top_zero) ctrl.set_err = 1'b1;
						else begin ctrl.div_go = 1'b1; state_d = ST_DIVWAIT; end
					end
					default: state_d = ST_WB;
				endcase
			end
			ST_SWP2: begin
				ctrl.swp_b = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIVWAIT: begin
				if (stat.div_done) begin
					ctrl.wr_res = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WB: begin
				if (stat.res_bad) ctrl.set_err = 1'b1;
				else ctrl.wr_res = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/sme_checker.sv
// ----------------------------------------------------------------------------
// sme_checker: port-level checks for the stack machine evaluator
// ----------------------------------------------------------------------------
module sme_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input sme_pkg::out_item_t out_item
);
	import sme_pkg::*;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_item.error |-> out_item.value == '0)
		else $error("error result with nonzero value");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> start)
		else $error("result without an accepted item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_item.error |-> out_item.value <= VAL_MAX && out_item.value >= VAL_MIN)
		else $error("result out of range");

endmodule

bind stack_machine_evaluator_top sme_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .out_item(out_item)
);

FILE: test/tb_stack_machine_evaluator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_machine_evaluator_top: self-checking bench for the stack calculator
// Drives command items, tracks stack/error state in a local predictor and
// checks every end result against a queue of predicted results.
// ----------------------------------------------------------------------------
module tb_stack_machine_evaluator_top;
	import sme_pkg::*;

	localparam int DEPTH = 16;
	localparam longint LIM = 1000000000;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_item_t  in_item;
	logic      busy;
	logic      done;
	out_item_t out_item;

	stack_machine_evaluator_top #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .done(done), .out_item(out_item)
	);

	// predictor state
	longint    calc_stack [DEPTH];
	int        calc_depth;
	bit        calc_err;
	out_item_t end_results [$];
	int        fails;
	int        idle_pct;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic bit out_rng(longint v);
		return v > LIM || v < -LIM;
	endfunction

	function automatic void calc_push(longint v);
		if (out_rng(v) || calc_depth >= DEPTH) calc_err = 1'b1;
		else begin
			calc_stack[calc_depth] = v;
			calc_depth++;
		end
	endfunction

	// Predicts the effect of one accepted item.
	function automatic void calc_apply(in_item_t it);
		longint top, below, r;
		out_item_t res;
		int t;
		if (it.cmd == CMD_START) begin
			calc_depth = 0;
			calc_err = 1'b0;
			calc_push(longint'(it.operand));
			return;
		end
		if (it.cmd == CMD_END) begin
			res.value = '0;
			res.error = 1'b1;
			if (!calc_err && calc_depth == 1) begin
				res.value = calc_stack[0][30:0];
				res.error = 1'b0;
			end
			end_results.push_back(res);
			return;
		end
		if (calc_err || it.cmd > CMD_END) return;
		case (it.cmd)
			CMD_NUM: calc_push(longint'(it.operand));
			CMD_POP, CMD_INV, CMD_DUP: begin
				if (calc_depth < 1) calc_err = 1'b1;
				else begin
					t = calc_depth - 1;
					if (it.cmd == CMD_POP) calc_depth--;
					else if (it.cmd == CMD_INV) calc_stack[t] = -calc_stack[t];
					else calc_push(calc_stack[t]);
				end
			end
			default: begin
				if (calc_depth < 2) begin
					calc_err = 1'b1;
					return;
				end
				t = calc_depth - 1;
				top = calc_stack[t];
				below = calc_stack[t-1];
				if (it.cmd == CMD_SWP) begin
					calc_stack[t] = below;
					calc_stack[t-1] = top;
					return;
				end
				case (it.cmd)
					CMD_ADD: r = below + top;
					CMD_SUB: r = below - top;
					CMD_MUL: r = below * top;
					default: begin
						if (top == 0) begin
							calc_err = 1'b1;
							return;
						end
						// SV / and % truncate toward zero like C
						r = (it.cmd == CMD_DIV) ? below / top : below % top;
					end
				endcase
				if (out_rng(r)) calc_err = 1'b1;
				else begin
					calc_stack[t-1] = r;
					calc_depth--;
				end
			end
		endcase
	endfunction

	// Sends one item, honoring the current idle percentage.
	// The prediction goes in before the item is offered, so an end result
	// is already queued at the edge that takes it.
	task automatic send_item(logic [3:0] c, logic signed [31:0] v);
		in_item_t it;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		it.cmd = c;
		it.operand = v;
		calc_apply(it);
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Result checker: done is a one-cycle strobe sampled at the edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (end_results.size() == 0) begin
				$display("%0t: unexpected result value=%0d error=%0b", $time,
					out_item.value, out_item.error);
				fails++;
			end else begin
				if (out_item.value !== end_results[0].value) begin
					$display("%0t: value expected %0d actual %0d", $time,
						end_results[0].value, out_item.value);
					fails++;
				end
				if (out_item.error !== end_results[0].error) begin
					$display("%0t: error expected %0b actual %0b", $time,
						end_results[0].error, out_item.error);
					fails++;
				end
				void'(end_results.pop_front());
			end
		end
	end

	function automatic logic signed [31:0] rnd_val();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1000000000, 0);
			2: return 32'(-$signed({1'b0, $urandom_range(1000000000, 0)}));
			3: return $urandom_range(1000000000, 999999990);
			4: return 32'(-$signed({1'b0, $urandom_range(1000000001, 999999990)}));
			default: return $signed($urandom_range(40)) - 20;
		endcase
	endfunction

	// extremes, every command, and the named corner cases
	task automatic test_directed();
		send_item(CMD_END, 0);            // no start: empty stack
		send_item(CMD_POP, 0);
		send_item(CMD_END, 0);
		send_item(CMD_START, 32'sd1000000000);
		send_item(CMD_NUM, -32'sd1000000000);
		send_item(CMD_ADD, 0);
		send_item(CMD_NUM, 7);
		send_item(CMD_SWP, 0);
		send_item(CMD_INV, 0);
		send_item(CMD_DUP, 0);
		send_item(CMD_MUL, 0);
		send_item(CMD_NUM, -3);
		send_item(CMD_DIV, 0);
		send_item(CMD_NUM, 3);
		send_item(CMD_MOD, 0);
		send_item(CMD_SUB, 0);
		send_item(4'd12, 0);              // unused code
		send_item(CMD_END, 0);            // one entry left: valid result
		send_item(CMD_START, 32'sh7fffffff); // out-of-range push
		send_item(CMD_END, 0);
		send_item(CMD_START, 32'sh80000000);
		send_item(CMD_START, 5);
		send_item(CMD_NUM, 0);
		send_item(CMD_DIV, 0);            // zero divisor
		send_item(CMD_END, 0);
		send_item(CMD_END, 0);            // repeat end
	endtask

	task automatic test_overflow();
		send_item(CMD_START, 1);
		repeat (DEPTH) send_item(CMD_DUP, 0);
		send_item(CMD_END, 0);
		send_item(CMD_START, 2);
		repeat (DEPTH - 1) send_item(CMD_NUM, 1);
		repeat (DEPTH - 1) send_item(CMD_ADD, 0);
		send_item(CMD_END, 0);
	endtask

	// mostly well-formed programs, with some noise
	task automatic test_random(int n_items, int pct);
		int sent;
		int len;
		idle_pct = pct;
		sent = 0;
		while (sent < n_items) begin
			send_item(CMD_START, rnd_val());
			len = $urandom_range(8);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(3) == 0) send_item(CMD_NUM, rnd_val());
				else send_item(4'($urandom_range(15)), rnd_val());
			end
			send_item(CMD_END, rnd_val());
			sent += len + 2;
		end
	endtask

	initial begin
		fails = 0;
		idle_pct = 0;
		calc_depth = 0;
		calc_err = 1'b0;
		start = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random(300, 0);
		test_random(300, 53);
		test_random(250, 18);
		test_random(250, 0);
		start <= 1'b0;
		while (end_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: stack_machine_evaluator_top.f
hw/rtl/sme_pkg.sv
hw/rtl/sme_div.sv
hw/rtl/sme_datapath.sv
hw/rtl/sme_ctrl.sv
hw/rtl/stack_machine_evaluator_top.sv
hw/rtl/sme_checker.sv
test/tb_stack_machine_evaluator_top.sv
